/* design/gra_pkg.sv */
// Package: command codes and configuration indices for the grid rectangle allocator.
`timescale 1ns / 1ps
package gra_pkg;
  localparam logic [2:0] CMD_PLACE = 3'd0;
  localparam logic [2:0] CMD_FIT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_FIND = 3'd3;
  localparam logic [2:0] CMD_CHECK = 3'd4;
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;
endpackage

/* design/gra_if.sv */
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface gra_req_if #(parameter int ID_BITS = 8);
  logic valid;
  logic ready;
  logic [2:0] cmd;
  logic [ID_BITS-1:0] item_id;
  logic [3:0] item_width;
  logic [3:0] item_height;
  logic [7:0] cell_index;
  modport source(output valid, cmd, item_id, item_width, item_height, cell_index, input ready);
  modport sink(input valid, cmd, item_id, item_width, item_height, cell_index, output ready);
endinterface

interface gra_rsp_if;
  logic valid;
  logic ready;
  logic ok;
  logic [7:0] placed_index;
  logic rotated;
  modport source(output valid, ok, placed_index, rotated, input ready);
  modport sink(input valid, ok, placed_index, rotated, output ready);
endinterface

interface gra_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [4:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* design/grid_rectangle_allocator_unit.sv */
// Top level: grid rectangle allocator with sequencer around the cell memory.
//
// Usage: requests arrive on req (cmd, item_id, item_width, item_height,
// cell_index); each request yields one transfer on rsp (ok, placed_index,
// rotated). The user must write the grid size on cfg (index 0 columns,
// index 1 rows) only while idle; the block itself does not enforce it.
// One request is handled at a time; req.ready is high only when idle.
// Operation: place/check first split cell_index into column and row, one
// grid row per step above the start cell, then probe the covered cells
// with one memory read each; place then fills the rectangle. Remove and
// find walk the live cells. First fit tries each start index in raster
// order, probing the covered cells (one memory read each), then fills the
// rectangle, and may repeat the scan with width and height swapped. The
// single memory port serialises every read and write.
// Reset: a clearing pass writes zero to every cell, one per cycle; no
// request is accepted during the pass.
// The result sits in an output register until rsp.ready; while it waits the
// block takes no new request.
module grid_rectangle_allocator_unit #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16,
  parameter int ID_BITS = 8,
  parameter int MAX_ITEM_DIM = 8
) (
  input logic clk,
  input logic rst,
  gra_req_if.sink req,
  gra_rsp_if.source rsp,
  gra_cfg_if.sink cfg
);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_PROBE, S_WAIT, S_TEST, S_FILL, S_SCAN, S_SWAIT, S_STEST,
    S_DONE
  } state_t;

  state_t state;
  logic [4:0] cols_reg, rows_reg;
  logic [2:0] cmd;
  logic [ID_BITS-1:0] id;
  logic [4:0] w, h;
  logic [7:0] start;
  logic [4:0] sx, sy;   // start position
  logic [4:0] dx, dy;   // offset within rectangle
  logic [8:0] scan;
  logic rot;
  logic ok;
  logic [7:0] placed_index;
  logic rotated;
  logic rsp_valid;

  // effective grid size
  logic [4:0] ec, er;
  logic [9:0] live;
  always_comb begin
    ec = (cols_reg == 5'd0) ? 5'd1 :
         (cols_reg > 5'(MAX_COLS)) ? 5'(MAX_COLS) : cols_reg;
    er = (rows_reg == 5'd0) ? 5'd1 :
         (rows_reg > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : rows_reg;
    live = 10'(ec) * 10'(er);
  end

  // memory port
  logic we;
  logic [AW-1:0] addr;
  logic [ID_BITS-1:0] wdata, rdata;
  logic [11:0] cell_lin;
  assign cell_lin = 12'(sx + dx) + 12'(sy + dy) * 12'(ec);

  gra_ram #(.WIDTH(ID_BITS), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  always_comb begin
    we = 1'b0;
    wdata = '0;
    addr = AW'(cell_lin % 12'(CELLS));
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        addr = AW'(scan);
      end
      S_FILL: begin
        we = 1'b1;
        wdata = id;
      end
      S_SCAN, S_SWAIT: addr = AW'(scan);
      S_STEST: begin
        addr = AW'(scan);
        we = (cmd == gra_pkg::CMD_REMOVE) && (rdata == id);
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.ok = ok;
  assign rsp.placed_index = placed_index;
  assign rsp.rotated = rotated;

  logic dims_ok;
  assign dims_ok = (req.item_width != 4'd0) && (req.item_height != 4'd0) &&
                   (req.item_width <= 4'(MAX_ITEM_DIM)) &&
                   (req.item_height <= 4'(MAX_ITEM_DIM));

  // start fits within grid
  logic bounds_ok;
  assign bounds_ok = (6'(sx) + 6'(w) <= 6'(ec)) && (6'(sy) + 6'(h) <= 6'(er));

  // last start position reached for first fit
  logic last_start;
  assign last_start = (10'(sy) * 10'(ec) + 10'(sx) + 10'd1) >= live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan <= '0;
      cols_reg <= 5'd16;
      rows_reg <= 5'd16;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == gra_pkg::CFG_COLS) cols_reg <= cfg.data;
        else rows_reg <= cfg.data;
      end
      unique case (state)
        S_CLEAR: begin
          scan <= scan + 9'd1;
          if (scan == 9'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd <= req.cmd;
            id <= req.item_id;
            w <= 5'(req.item_width);
            h <= 5'(req.item_height);
            start <= req.cell_index;
            sx <= '0;
            sy <= '0;
            dx <= '0;
            dy <= '0;
            scan <= '0;
            rot <= 1'b0;
            ok <= 1'b0;
            placed_index <= '0;
            rotated <= 1'b0;
            state <= S_DONE;
            if (req.item_id != '0) begin
              priority case (req.cmd)
                gra_pkg::CMD_PLACE, gra_pkg::CMD_CHECK: begin
                  if (dims_ok && 9'(req.cell_index) < 9'(live)) begin
                    scan <= 9'(req.cell_index);
                    state <= S_DIV;
                  end
                end
                gra_pkg::CMD_FIT: begin
                  if (dims_ok) state <= S_PROBE;
                end
                gra_pkg::CMD_REMOVE, gra_pkg::CMD_FIND: state <= S_SCAN;
                default: ;
              endcase
            end
          end
        end
        S_DIV: begin
          // split the start index into column and row, one row per cycle
          if (scan >= 9'(ec)) begin
            scan <= scan - 9'(ec);
            sy <= sy + 5'd1;
          end else begin
            sx <= 5'(scan);
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          // bounds check; on success read the first cell, else next start, rotate or finish
          dx <= '0;
          dy <= '0;
          if (bounds_ok) state <= S_WAIT;
          else if (cmd == gra_pkg::CMD_FIT && !last_start) begin
            if (sx + 5'd1 >= ec) begin
              sx <= '0;
              sy <= sy + 5'd1;
            end else sx <= sx + 5'd1;
          end else if (cmd == gra_pkg::CMD_FIT && !rot) begin
            rot <= 1'b1;
            w <= h;
            h <= w;
            sx <= '0;
            sy <= '0;
          end else state <= S_DONE;
        end
        S_WAIT: state <= S_TEST;
        S_TEST: begin
          if (rdata != '0) begin
            if (cmd == gra_pkg::CMD_FIT && !last_start) begin
              if (sx + 5'd1 >= ec) begin
                sx <= '0;
                sy <= sy + 5'd1;
              end else sx <= sx + 5'd1;
              state <= S_PROBE;
            end else if (cmd == gra_pkg::CMD_FIT && !rot) begin
              rot <= 1'b1;
              w <= h;
              h <= w;
              sx <= '0;
              sy <= '0;
              state <= S_PROBE;
            end else state <= S_DONE;
          end else if (dx + 5'd1 < w) begin
            dx <= dx + 5'd1;
            state <= S_WAIT;
          end else if (dy + 5'd1 < h) begin
            dx <= '0;
            dy <= dy + 5'd1;
            state <= S_WAIT;
          end else begin
            ok <= 1'b1;
            dx <= '0;
            dy <= '0;
            if (cmd == gra_pkg::CMD_CHECK) state <= S_DONE;
            else begin
              placed_index <= (cmd == gra_pkg::CMD_FIT) ?
                8'(10'(sy) * 10'(ec) + 10'(sx)) : start;
              rotated <= rot;
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (dx + 5'd1 < w) dx <= dx + 5'd1;
          else if (dy + 5'd1 < h) begin
            dx <= '0;
            dy <= dy + 5'd1;
          end else state <= S_DONE;
        end
        S_SCAN: state <= S_SWAIT;
        S_SWAIT: state <= S_STEST;
        S_STEST: begin
          if (rdata == id) ok <= 1'b1;
          if ((rdata == id && cmd == gra_pkg::CMD_FIND) ||
              10'(scan) + 10'd1 >= live || scan + 9'd1 >= 9'(CELLS)) state <= S_DONE;
          else begin
            scan <= scan + 9'd1;
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!rsp_valid) begin
            rsp_valid <= 1'b1;
          end else if (rsp.ready) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/gra_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module gra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* design/gra_checker.sv */
// Port-level checker for the grid rectangle allocator, bound to the top level.
`timescale 1ns / 1ps
module gra_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic ok,
  input logic [7:0] placed_index,
  input logic rotated
);
  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  // a failed result carries no placement
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> (placed_index == 8'd0 && !rotated))
    else $error("failed result with placement");
  // result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(ok) && $stable(placed_index)))
    else $error("result dropped");
  // after request transfer, ready drops
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready) else $error("ready stayed high");
endmodule

bind grid_rectangle_allocator_unit gra_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .ok(rsp.ok),
  .placed_index(rsp.placed_index), .rotated(rsp.rotated));
